/* src/adcrf_pkg.sv */
`default_nettype none

package adcrf_pkg;

    localparam int REGISTER_COUNT = 4;
    localparam int SAMPLE_BITS    = 12;

    localparam int PTR_W     = 2;
    localparam int DATA_W    = 16;
    localparam int CHAN_W    = 2;
    localparam int GAIN_W    = 3;
    localparam int REG_IDX_W = $clog2(REGISTER_COUNT);

    localparam int DIV_W = 13;
    localparam int Q_W   = 15;
    localparam int NUM_W = SAMPLE_BITS + Q_W;
    localparam int CMP_W = (SAMPLE_BITS > DIV_W) ? SAMPLE_BITS : DIV_W;
    localparam int CNT_W = $clog2(Q_W);

    localparam logic [DATA_W-1:0] FULL_SCALE = DATA_W'(32767);

    localparam int GAIN_LSB = 9;
    localparam int CHAN_LSB = 12;

    function automatic logic [DIV_W-1:0] gain_divisor(input logic [GAIN_W-1:0] gain);
        logic [DIV_W-1:0] d;
        case (gain)
            3'd0:    d = DIV_W'(7626);
            3'd1:    d = DIV_W'(5084);
            3'd2:    d = DIV_W'(2542);
            3'd3:    d = DIV_W'(1271);
            3'd4:    d = DIV_W'(635);
            3'd5:    d = DIV_W'(328);
            default: d = DIV_W'(2542);
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

/* src/adcrf_divider.sv */
`default_nettype none

module adcrf_divider (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [adcrf_pkg::NUM_W-1:0]  numer,
    input  wire logic [adcrf_pkg::DIV_W-1:0]  divisor,
    output logic                              done,
    output logic [adcrf_pkg::Q_W-1:0]         quotient
);
    import adcrf_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t             state_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   d_reg;
    logic [Q_W-1:0]     shq_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;

    logic [DIV_W:0]     trial;
    logic [DIV_W:0]     diff;
    logic               ge;
    logic [DIV_W-1:0]   rem_next;
    logic [Q_W-1:0]     shq_next;

    // One quotient bit per cycle: the next numerator bit enters the remainder.
    always_comb
    begin
        trial    = {rem_reg, shq_reg[Q_W-1]};
        diff     = trial - {1'b0, d_reg};
        ge       = (trial >= {1'b0, d_reg});
        rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        shq_next = {shq_reg[Q_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            rem_reg   <= '0;
            d_reg     <= '0;
            shq_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= DIV_W'(numer >> Q_W);
                        shq_reg   <= numer[Q_W-1:0];
                        d_reg     <= divisor;
                        cnt_reg   <= CNT_W'(Q_W - 1);
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    rem_reg <= rem_next;
                    shq_reg <= shq_next;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = shq_reg;

endmodule

`default_nettype wire

/* src/adc_register_file_with_scaling_core.sv */
`default_nettype none

// Channel  Signals                                         Direction
// -------  ----------------------------------------------  ---------
// in       in_valid, in_stall, req_type, reg_pointer,      sink
//          write_data, adc_sample
// out      out_valid, out_stall, read_data,                source
//          selected_channel
//
// A write beat and a read of a nonzero register do not use the divider.
// A read of register 0 below saturation waits for the bit-serial divider,
// which produces one of the 15 quotient bits per cycle; no beat is taken meanwhile.
// Reset clears the pointer and the register file at once; no clearing pass.
// A read beat is stalled while the output register holds an untaken beat;
// write beats are taken regardless of the output side.

module adc_register_file_with_scaling_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              req_type,
    input  wire logic [adcrf_pkg::PTR_W-1:0]       reg_pointer,
    input  wire logic [adcrf_pkg::DATA_W-1:0]      write_data,
    input  wire logic [adcrf_pkg::SAMPLE_BITS-1:0] adc_sample,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [adcrf_pkg::DATA_W-1:0]           read_data,
    output logic [adcrf_pkg::CHAN_W-1:0]           selected_channel
);
    import adcrf_pkg::*;

    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [DATA_W-1:0] regs_reg [REGISTER_COUNT];
    logic [DATA_W-1:0] regs_next [REGISTER_COUNT];
    logic              busy_reg, busy_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_data_reg, read_data_next;
    logic [CHAN_W-1:0] chan_reg, chan_next;

    logic              in_acc;
    logic              out_free;
    logic [DIV_W-1:0]  divisor;
    logic              sat;
    logic              div_start;
    logic [NUM_W-1:0]  numer;
    logic              div_done;
    logic [Q_W-1:0]    quotient;
    logic [DATA_W-1:0] cfg;

    assign cfg      = regs_reg[1];
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = busy_reg || (req_type && !out_free);
    assign in_acc   = in_valid && !in_stall;
    assign divisor  = gain_divisor(cfg[GAIN_LSB +: GAIN_W]);
    assign sat      = (CMP_W'(adc_sample) >= CMP_W'(divisor));
    assign numer    = {adc_sample, {Q_W{1'b0}}} - NUM_W'(adc_sample);

    always_comb
    begin
        ptr_next       = ptr_reg;
        regs_next      = regs_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        chan_next      = chan_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (in_acc)
        begin
            if (!req_type)
            begin
                ptr_next = reg_pointer;
                if ((reg_pointer != '0) && (32'(reg_pointer) < REGISTER_COUNT))
                begin
                    regs_next[REG_IDX_W'(reg_pointer)] = write_data;
                end
            end
            else
            begin
                chan_next = cfg[CHAN_LSB +: CHAN_W];
                if (ptr_reg == '0)
                begin
                    if (sat)
                    begin
                        regs_next[0]   = FULL_SCALE;
                        read_data_next = FULL_SCALE;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        busy_next = 1'b1;
                    end
                end
                else
                begin
                    out_valid_next = 1'b1;
                    if (32'(ptr_reg) < REGISTER_COUNT)
                    begin
                        read_data_next = regs_reg[REG_IDX_W'(ptr_reg)];
                    end
                    else
                    begin
                        read_data_next = '0;
                    end
                end
            end
        end

        if (div_done)
        begin
            busy_next      = 1'b0;
            regs_next[0]   = DATA_W'(quotient);
            read_data_next = DATA_W'(quotient);
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else
        begin
            ptr_reg       <= ptr_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            regs_reg      <= regs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_data_reg <= read_data_next;
        chan_reg      <= chan_next;
    end

    adcrf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign out_valid        = out_valid_reg;
    assign read_data        = read_data_reg;
    assign selected_channel = chan_reg;

`ifndef NO_ASSERTIONS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("input taken during a conversion");

    a_no_out_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && out_valid_reg))
        else $error("output beat pending during a conversion");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> busy_reg)
        else $error("divider finished without a pending conversion");

    a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        regs_reg[0][DATA_W-1] == 1'b0)
        else $error("conversion result above full scale");
`endif

endmodule

`default_nettype wire

/* verif/adcrf_read_checker.sv */
`timescale 1ns / 1ps

module adcrf_read_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic                              req_type,
    input  wire logic [adcrf_pkg::PTR_W-1:0]       reg_pointer,
    input  wire logic [adcrf_pkg::DATA_W-1:0]      write_data,
    input  wire logic [adcrf_pkg::SAMPLE_BITS-1:0] adc_sample,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [adcrf_pkg::DATA_W-1:0]      read_data,
    input  wire logic [adcrf_pkg::CHAN_W-1:0]      selected_channel,
    output int                                     reads_pending,
    output int                                     fail_count
);

    import adcrf_pkg::*;

    localparam logic REQ_WRITE = 1'b0;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CHAN_W-1:0] chan;
    } read_reply_t;

    read_reply_t       expected_replies[$];
    logic [PTR_W-1:0]  model_ptr;
    logic [DATA_W-1:0] model_regs[REGISTER_COUNT];
    int                fails;

    function automatic logic [DATA_W-1:0] converted_code(input logic [SAMPLE_BITS-1:0] sample,
                                                         input logic [GAIN_W-1:0] gain);
        int unsigned full_scale_div;
        int unsigned product;
        case (gain)
            3'd0:    full_scale_div = 7626;
            3'd1:    full_scale_div = 5084;
            3'd2:    full_scale_div = 2542;
            3'd3:    full_scale_div = 1271;
            3'd4:    full_scale_div = 635;
            3'd5:    full_scale_div = 328;
            default: full_scale_div = 2542;
        endcase
        if (sample >= full_scale_div)
            return 16'd32767;
        product = int'(sample) * 32767;
        return DATA_W'(product / full_scale_div);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        read_reply_t       got;
        read_reply_t       want;
        logic [DATA_W-1:0] cfg;
        if (!rst_n)
        begin
            expected_replies.delete();
            model_ptr = '0;
            for (int i = 0; i < REGISTER_COUNT; i++)
                model_regs[i] = '0;
            fails = 0;
            reads_pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.data = read_data;
                got.chan = selected_channel;
                if (expected_replies.size() == 0)
                begin
                    $error("read_data: unexpected beat %h, channel %h", got.data, got.chan);
                    fails++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.data !== want.data)
                    begin
                        $error("read_data: expected %h, got %h", want.data, got.data);
                        fails++;
                    end
                    if (got.chan !== want.chan)
                    begin
                        $error("selected_channel: expected %h, got %h", want.chan, got.chan);
                        fails++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_WRITE)
                begin
                    model_ptr = reg_pointer;
                    if (model_ptr != '0)
                        model_regs[model_ptr] = write_data;
                end
                else
                begin
                    cfg = model_regs[1];
                    if (model_ptr == '0)
                        model_regs[0] = converted_code(adc_sample,
                                                       cfg[GAIN_LSB +: GAIN_W]);
                    want.data = model_regs[model_ptr];
                    want.chan = cfg[CHAN_LSB +: CHAN_W];
                    expected_replies.push_back(want);
                end
            end
            reads_pending <= expected_replies.size();
            fail_count <= fails;
        end
    end

endmodule

/* verif/adc_register_file_with_scaling_core_tb.sv */
`timescale 1ns / 1ps

module adc_register_file_with_scaling_core_tb;

    import adcrf_pkg::*;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_READ    = 1'b1;
    localparam int   QUIET_LIMIT = 5000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_type;
    logic [PTR_W-1:0]       reg_pointer;
    logic [DATA_W-1:0]      write_data;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [DATA_W-1:0]      read_data;
    logic [CHAN_W-1:0]      selected_channel;

    int reads_pending;
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    int beats_sent;
    int quiet_cycles;

    adc_register_file_with_scaling_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .reg_pointer      (reg_pointer),
        .write_data       (write_data),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .selected_channel (selected_channel)
    );

    adcrf_read_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .req_type         (req_type),
        .reg_pointer      (reg_pointer),
        .write_data       (write_data),
        .adc_sample       (adc_sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .read_data        (read_data),
        .selected_channel (selected_channel),
        .reads_pending    (reads_pending),
        .fail_count       (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("adc_register_file_with_scaling_core regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_beat(input logic req, input logic [PTR_W-1:0] ptr,
                             input logic [DATA_W-1:0] data,
                             input logic [SAMPLE_BITS-1:0] sample);
        logic accepted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        reg_pointer <= ptr;
        write_data  <= data;
        adc_sample  <= sample;
        // The stall is sampled mid-cycle, where it holds the value seen at the next edge.
        do
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        while (!accepted);
        beats_sent++;
    endtask

    task automatic write_reg(input logic [PTR_W-1:0] ptr, input logic [DATA_W-1:0] data);
        send_beat(REQ_WRITE, ptr, data, SAMPLE_BITS'($urandom()));
    endtask

    task automatic read_reg(input logic [SAMPLE_BITS-1:0] sample);
        send_beat(REQ_READ, PTR_W'($urandom()), DATA_W'($urandom()), sample);
    endtask

    task automatic drain_reads();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reads_pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return SAMPLE_BITS'($urandom());
            1:       return SAMPLE_BITS'($urandom_range(0, 700));
            2:       return SAMPLE_BITS'($urandom_range(1200, 2600));
            default: return SAMPLE_BITS'($urandom_range(3900, 4095));
        endcase
    endfunction

    task automatic run_phase(input int target, input int send_pct, input int recv_pct);
        int stop_at;
        int reps;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        stop_at = beats_sent + target;
        while (beats_sent < stop_at)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    write_reg(PTR_W'(1), DATA_W'($urandom()));
                2, 3, 4, 5, 6:
                begin
                    if ($urandom_range(0, 1) == 0)
                        write_reg('0, DATA_W'($urandom()));
                    else
                        write_reg(PTR_W'($urandom()), DATA_W'($urandom()));
                    reps = $urandom_range(1, 5);
                    repeat (reps)
                        read_reg(pick_sample());
                end
                7:
                    read_reg(pick_sample());
                default:
                    write_reg(PTR_W'($urandom_range(2, 3)), DATA_W'($urandom()));
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_WRITE;
        reg_pointer   = '0;
        write_data    = '0;
        adc_sample    = '0;
        out_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        beats_sent    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        read_reg('0);
        read_reg(12'hFFF);
        write_reg(PTR_W'(1), 16'hFA00);
        write_reg('0, 16'hFFFF);
        read_reg(12'd327);
        read_reg(12'd328);
        write_reg(PTR_W'(1), 16'h0C00);
        write_reg('0, 16'h0000);
        read_reg(12'd2541);
        write_reg(PTR_W'(1), 16'h2FFF);
        write_reg('0, 16'h1234);
        read_reg(12'd2542);
        write_reg(PTR_W'(2), 16'hFFFF);
        read_reg(12'hFFF);
        write_reg(PTR_W'(3), 16'h0000);
        read_reg('0);
        write_reg(PTR_W'(1), 16'h5600);
        read_reg('0);
        write_reg('0, 16'h0000);
        read_reg(12'd1270);
        read_reg(12'd1271);
        write_reg(PTR_W'(1), 16'h4800);
        write_reg('0, 16'h0000);
        read_reg(12'd634);
        read_reg(12'd635);
        drain_reads();

        run_phase(375, 35, 46);
        drain_reads();
        run_phase(375, 46, 35);
        drain_reads();
        run_phase(375, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (reads_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("adc_register_file_with_scaling_core regression: pass");
        else
            $display("adc_register_file_with_scaling_core regression: fail");
        $finish;
    end

endmodule

/* sim.f */
src/adcrf_pkg.sv
src/adcrf_divider.sv
src/adc_register_file_with_scaling_core.sv
verif/adcrf_read_checker.sv
verif/adc_register_file_with_scaling_core_tb.sv
